// ===== hdl/interval_timer_three_channel_assert.svh =====
// assertion macros for the interval timer checker
// no dependencies; included by the checker file
`ifndef INTERVAL_TIMER_THREE_CHANNEL_ASSERT_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ITC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itc check failed");

// next-cycle implication, disabled during reset
`define ITC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itc check failed");

// next-cycle implication that also covers reset cycles
`define ITC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("itc check failed");

`endif

// ===== hdl/itc_pkg.sv =====
// shared types and constants for the three-channel interval timer
// no dependencies
`default_nettype none

package itc_pkg;

    localparam int CNT_W = 16;

    // transaction kinds on the input channel
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // byte access codes from the mode command
    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_BOTH  = 2'd3
    } t_access;

    localparam logic [1:0] MODE_PORT = 2'd3;

    // per-channel operation for the current transaction
    typedef struct packed {
        logic       wr_mode;
        logic       wr_count;
        logic       rd_count;
        logic       tick;
        logic [7:0] data;
    } t_chan_op;

endpackage

`default_nettype wire

// ===== hdl/itc_if.sv =====
// valid/ready channel interfaces for timer transactions and results
// no dependencies
`default_nettype none

interface itc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] port;
    logic [7:0] write_data;

    modport source (output valid, output command, output port, output write_data,
                    input ready);
    modport sink (input valid, input command, input port, input write_data,
                  output ready);
endinterface

interface itc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [2:0] out_levels;

    modport source (output valid, output read_data, output out_levels, input ready);
    modport sink (input valid, input read_data, input out_levels, output ready);
endinterface

`default_nettype wire

// ===== hdl/itc_channel.sv =====
// one counter channel: mode, count load, read access and tick stepping
// depends on itc_pkg
`default_nettype none

module itc_channel
    import itc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_chan_op i_op,
    output logic [7:0]    o_rd_byte,
    output logic          o_level_next
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_reload, n_reload;
    logic [CNT_W-1:0] r_latched, n_latched;
    logic             r_latch_held, n_latch_held;
    logic             r_read_high, n_read_high;
    logic             r_write_high, n_write_high;
    logic [7:0]       r_pending, n_pending;
    logic [2:0]       r_mode, n_mode;
    t_access          r_access, n_access;
    logic             r_level, n_level;
    logic             r_armed, n_armed;

    // next-state logic for one transaction
    always_comb begin
        logic [CNT_W-1:0] load_val;
        logic             do_load;
        logic             square;
        logic [CNT_W-1:0] rd_val;
        logic [1:0]       step;
        logic [CNT_W-1:0] dec;

        n_count      = r_count;
        n_reload     = r_reload;
        n_latched    = r_latched;
        n_latch_held = r_latch_held;
        n_read_high  = r_read_high;
        n_write_high = r_write_high;
        n_pending    = r_pending;
        n_mode       = r_mode;
        n_access     = r_access;
        n_level      = r_level;
        n_armed      = r_armed;
        o_rd_byte    = 8'd0;
        load_val     = '0;
        do_load      = 1'b0;
        square       = (r_mode[1:0] == 2'b11);
        rd_val       = r_latch_held ? r_latched : r_count;
        step         = 2'd2;
        dec          = r_count - 16'd1;

        // mode command or latch
        if (i_op.wr_mode) begin
            if (t_access'(i_op.data[5:4]) == ACC_LATCH) begin
                if (!r_latch_held) begin
                    n_latched    = r_count;
                    n_latch_held = 1'b1;
                end
            end else begin
                n_access     = t_access'(i_op.data[5:4]);
                n_mode       = i_op.data[3:1];
                n_armed      = 1'b0;
                n_read_high  = 1'b0;
                n_write_high = 1'b0;
                n_latch_held = 1'b0;
                n_level      = (i_op.data[2:1] == 2'b11);
            end
        end

        // count write
        if (i_op.wr_count) begin
            case (r_access)
                ACC_LOW: begin
                    load_val = {8'd0, i_op.data};
                    do_load  = 1'b1;
                end
                ACC_HIGH: begin
                    load_val = {i_op.data, 8'd0};
                    do_load  = 1'b1;
                end
                default: begin
                    if (!r_write_high) begin
                        n_pending    = i_op.data;
                        n_write_high = 1'b1;
                        if (!square) begin
                            n_armed = 1'b0;
                            n_level = 1'b0;
                        end
                    end else begin
                        n_write_high = 1'b0;
                        load_val     = {i_op.data, r_pending};
                        do_load      = 1'b1;
                    end
                end
            endcase
        end

        // complete load of the reload value
        if (do_load) begin
            n_reload = load_val;
            if (square) begin
                if (!r_armed) begin
                    n_count = load_val;
                    n_armed = 1'b1;
                end
            end else begin
                n_count = load_val;
                n_armed = 1'b1;
                n_level = 1'b0;
            end
        end

        // count read, latched value first
        if (i_op.rd_count) begin
            case (r_access)
                ACC_LOW: begin
                    o_rd_byte    = rd_val[7:0];
                    n_latch_held = 1'b0;
                end
                ACC_HIGH: begin
                    o_rd_byte    = rd_val[15:8];
                    n_latch_held = 1'b0;
                end
                default: begin
                    if (!r_read_high) begin
                        o_rd_byte   = rd_val[7:0];
                        n_read_high = 1'b1;
                    end else begin
                        o_rd_byte    = rd_val[15:8];
                        n_read_high  = 1'b0;
                        n_latch_held = 1'b0;
                    end
                end
            endcase
        end

        // one input clock tick
        if (i_op.tick && r_armed) begin
            if (square) begin
                if (r_count[0]) begin
                    step = r_level ? 2'd1 : 2'd3;
                end
                if (r_count != '0 && r_count <= {14'd0, step}) begin
                    n_level = !r_level;
                    n_count = r_reload;
                end else begin
                    n_count = r_count - {14'd0, step};
                end
            end else begin
                n_count = dec;
                if (dec == '0) begin
                    n_level = 1'b1;
                end
            end
        end
    end

    assign o_level_next = n_level;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_reload     <= '0;
            r_latch_held <= 1'b0;
            r_read_high  <= 1'b0;
            r_write_high <= 1'b0;
            r_mode       <= 3'd0;
            r_access     <= ACC_BOTH;
            r_level      <= 1'b0;
            r_armed      <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_reload     <= n_reload;
            r_latch_held <= n_latch_held;
            r_read_high  <= n_read_high;
            r_write_high <= n_write_high;
            r_mode       <= n_mode;
            r_access     <= n_access;
            r_level      <= n_level;
            r_armed      <= n_armed;
        end
    end

    // payload holding registers, only read once written
    always_ff @(posedge i_clk) begin
        r_latched <= n_latched;
        r_pending <= n_pending;
    end

endmodule

`default_nettype wire

// ===== hdl/interval_timer_three_channel.sv =====
// Datapath: an input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; the single-pass channel logic between the two
// registers sets it, and input ready stays high whenever the result side is ready.
// Reset: synchronous active-low; clears all channels (access low then high, disarmed,
// outputs low) and empties both register stages.
// depends on itc_pkg, itc_if, itc_channel
`default_nettype none

module interval_timer_three_channel
    import itc_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itc_in_if.sink     i_in,
    itc_out_if.source  o_out
);

    logic       r_in_valid;
    t_cmd       r_cmd;
    logic [1:0] r_port;
    logic [7:0] r_data;
    logic       r_out_valid;
    logic [7:0] r_rd;
    logic [2:0] r_lvl;
    logic       advance;
    t_chan_op   ch_op [NUM_CHANNELS];
    logic [7:0] ch_rd [NUM_CHANNELS];
    logic [2:0] n_lvl;
    logic [7:0] n_rd;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= t_cmd'(i_in.command);
            r_port <= i_in.port;
            r_data <= i_in.write_data;
        end
    end

    // per-channel decode and channel instances
    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
        always_comb begin
            ch_op[i].wr_mode  = advance && r_cmd == CMD_WRITE && r_port == MODE_PORT
                                && r_data[7:6] == 2'(i);
            ch_op[i].wr_count = advance && r_cmd == CMD_WRITE && r_port == 2'(i);
            ch_op[i].rd_count = advance && r_cmd == CMD_READ && r_port == 2'(i);
            ch_op[i].tick     = advance && r_cmd == CMD_TICK;
            ch_op[i].data     = r_data;
        end

        itc_channel u_channel (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (ch_op[i]),
            .o_rd_byte    (ch_rd[i]),
            .o_level_next (n_lvl[i])
        );
    end

    for (genvar i = NUM_CHANNELS; i < 3; i++) begin : g_absent
        assign n_lvl[i] = 1'b0;
    end

    // read data: only the addressed channel drives a nonzero byte
    always_comb begin
        n_rd = 8'd0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_rd = n_rd | ch_rd[i];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rd  <= n_rd;
            r_lvl <= n_lvl;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_rd;
    assign o_out.out_levels = r_lvl;

endmodule

`default_nettype wire

// ===== hdl/itc_checker.sv =====
// port-level checks for the interval timer, bound to the top level
// depends on interval_timer_three_channel_assert.svh
`default_nettype none

`include "interval_timer_three_channel_assert.svh"

module itc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    // a stalled result stays offered
    `ITC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // reset empties the result stage
    `ITC_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)
    // a ready result side never stalls the input side
    `ITC_ASSERT_SAME(a_no_stall, i_clk, i_rst_n, i_out_ready, i_in_ready)
    // an accepted transaction moves from the input register to the result stage when the result side is ready
    `ITC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_in_valid && i_in_ready ##1 i_out_ready, i_out_valid)

endmodule

bind interval_timer_three_channel itc_checker u_itc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

`default_nettype wire
